FILE: design/rfz_pkg.sv
// ----------------------------------------------------------------------------
// rfz_pkg
// Types and constants shared by the radio failsafe and throttle-zero monitor.
// ----------------------------------------------------------------------------
package rfz_pkg;

    localparam int unsigned LOW_CNT_W = 2;

    localparam logic [LOW_CNT_W-1:0] LOW_COUNT_LIMIT = LOW_CNT_W'(3);

    localparam logic CMD_POLL  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    typedef enum logic [1:0] {
        CFG_FAILSAFE_ENABLE  = 2'd0,
        CFG_LOW_THROTTLE_PWM = 2'd1,
        CFG_FRAME_TIMEOUT_MS = 2'd2,
        CFG_ZERO_DEBOUNCE_MS = 2'd3
    } cfg_index_t;

    localparam int unsigned CFG_DATA_W = 16;

    localparam logic        RST_FAILSAFE_ENABLE  = 1'b1;
    localparam logic [11:0] RST_LOW_THROTTLE_PWM = 12'd975;
    localparam logic [15:0] RST_FRAME_TIMEOUT_MS = 16'd1000;
    localparam logic [15:0] RST_ZERO_DEBOUNCE_MS = 16'd400;

    typedef struct packed {
        logic        command;
        logic [31:0] now_ms;
        logic [11:0] throttle_pulse;
        logic [9:0]  throttle_level;
        logic        motors_armed;
        logic        interlock_in_use;
        logic        interlock_on;
        logic        estop_active;
        logic        airmode_active;
    } item_t;

    typedef struct packed {
        logic                 failsafe_active;
        logic                 throttle_idle;
        logic                 receiver_present;
        logic [LOW_CNT_W-1:0] low_count;
    } result_t;

    typedef struct packed {
        logic        failsafe_enable;
        logic [11:0] low_throttle_pwm;
        logic [15:0] frame_timeout_ms;
        logic [15:0] zero_debounce_ms;
    } cfg_t;

endpackage

FILE: design/rfz_if.sv
// ----------------------------------------------------------------------------
// rfz_if
// Valid/ready channels for input items and results of the monitor.
// ----------------------------------------------------------------------------
interface rfz_item_if;
    logic           valid;
    logic           ready;
    rfz_pkg::item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface rfz_result_if;
    logic             valid;
    logic             ready;
    rfz_pkg::result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: design/rfz_core.sv
// ----------------------------------------------------------------------------
// rfz_core
// Monitor state and its per-transaction update: low-throttle counter,
// failsafe flag, frame timeout and throttle-zero debounce.
// ----------------------------------------------------------------------------
module rfz_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  rfz_pkg::item_t   item,
    input  rfz_pkg::cfg_t    cfg,
    output rfz_pkg::result_t result
);

    logic                          failsafe_reg, failsafe_next;
    logic [rfz_pkg::LOW_CNT_W-1:0] low_cnt_reg, low_cnt_next;
    logic                          seen_reg, seen_next;
    logic [31:0]                   last_frame_reg, last_frame_next;
    logic [31:0]                   last_run_reg, last_run_next;
    logic                          zero_reg, zero_next;

    logic        running;
    logic        pwm_low;
    logic [31:0] run_elapsed;
    logic [31:0] frame_elapsed;

    assign pwm_low       = item.throttle_pulse < cfg.low_throttle_pwm;
    assign run_elapsed   = item.now_ms - last_run_reg;
    assign frame_elapsed = item.now_ms - last_frame_reg;
    assign running       = (!item.interlock_in_use && (item.throttle_level != 10'd0)
                            && !item.estop_active)
                           || (item.interlock_in_use && item.interlock_on)
                           || item.airmode_active;

    always_comb
    begin
        failsafe_next   = failsafe_reg;
        low_cnt_next    = low_cnt_reg;
        seen_next       = seen_reg;
        last_frame_next = last_frame_reg;
        last_run_next   = last_run_reg;
        zero_next       = zero_reg;

        if (item.command == rfz_pkg::CMD_FRAME)
        begin
            if (cfg.failsafe_enable)
            begin
                if (pwm_low)
                begin
                    if (!failsafe_reg && (seen_reg || item.motors_armed))
                    begin
                        if (low_cnt_reg >= rfz_pkg::LOW_COUNT_LIMIT - 1'b1)
                        begin
                            low_cnt_next  = rfz_pkg::LOW_COUNT_LIMIT;
                            failsafe_next = 1'b1;
                        end
                        else
                        begin
                            low_cnt_next = low_cnt_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    if (low_cnt_reg != '0)
                    begin
                        low_cnt_next = low_cnt_reg - 1'b1;
                    end
                    if (low_cnt_reg <= rfz_pkg::LOW_CNT_W'(1))
                    begin
                        failsafe_next = 1'b0;
                    end
                end
            end

            if (running)
            begin
                last_run_next = item.now_ms;
                zero_next     = 1'b0;
            end
            else if (run_elapsed > {16'd0, cfg.zero_debounce_ms})
            begin
                zero_next = 1'b1;
            end

            seen_next       = 1'b1;
            last_frame_next = item.now_ms;
        end
        else if (!failsafe_reg)
        begin
            if ((frame_elapsed >= {16'd0, cfg.frame_timeout_ms}) && cfg.failsafe_enable
                && (seen_reg || item.motors_armed))
            begin
                failsafe_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            failsafe_reg   <= 1'b0;
            low_cnt_reg    <= '0;
            seen_reg       <= 1'b0;
            last_frame_reg <= '0;
            last_run_reg   <= '0;
            zero_reg       <= 1'b1;
        end
        else if (load)
        begin
            failsafe_reg   <= failsafe_next;
            low_cnt_reg    <= low_cnt_next;
            seen_reg       <= seen_next;
            last_frame_reg <= last_frame_next;
            last_run_reg   <= last_run_next;
            zero_reg       <= zero_next;
        end
    end

    assign result.failsafe_active  = failsafe_next;
    assign result.throttle_idle    = zero_next;
    assign result.receiver_present = seen_next;
    assign result.low_count        = low_cnt_next;

endmodule

FILE: design/radio_failsafe_throttle_zero_monitor_unit.sv
// ----------------------------------------------------------------------------
// radio_failsafe_throttle_zero_monitor_unit
// Radio failsafe and throttle-zero monitor, one result per input transaction.
// ----------------------------------------------------------------------------
// Each accepted transaction (poll or radio frame) yields exactly one result
// transaction carrying failsafe, throttle-zero, receiver-present and the
// low-throttle count after the update. A transaction passes an input register
// and then the state update into the result register; one transaction is taken
// every cycle as long as results are taken; that update is combinational.
// Configuration registers are written through cfg_we, cfg_index and cfg_data,
// by the user only while no transaction is in flight (the block does not
// enforce this), and take effect on the next transaction.
module radio_failsafe_throttle_zero_monitor_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    rfz_item_if.sink                         item,
    rfz_result_if.source                     result,
    input  logic                             cfg_we,
    input  rfz_pkg::cfg_index_t              cfg_index,
    input  logic [rfz_pkg::CFG_DATA_W-1:0]   cfg_data
);

    rfz_pkg::cfg_t    cfg_reg;
    logic             in_valid_reg;
    rfz_pkg::item_t   in_item_reg;
    logic             out_valid_reg;
    rfz_pkg::result_t out_result_reg;
    rfz_pkg::result_t result_next;
    logic             out_free;
    logic             load;

    assign out_free   = !out_valid_reg || result.ready;
    assign load       = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || out_free;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.failsafe_enable  <= rfz_pkg::RST_FAILSAFE_ENABLE;
            cfg_reg.low_throttle_pwm <= rfz_pkg::RST_LOW_THROTTLE_PWM;
            cfg_reg.frame_timeout_ms <= rfz_pkg::RST_FRAME_TIMEOUT_MS;
            cfg_reg.zero_debounce_ms <= rfz_pkg::RST_ZERO_DEBOUNCE_MS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rfz_pkg::CFG_FAILSAFE_ENABLE:  cfg_reg.failsafe_enable  <= cfg_data[0];
                rfz_pkg::CFG_LOW_THROTTLE_PWM: cfg_reg.low_throttle_pwm <= cfg_data[11:0];
                rfz_pkg::CFG_FRAME_TIMEOUT_MS: cfg_reg.frame_timeout_ms <= cfg_data;
                rfz_pkg::CFG_ZERO_DEBOUNCE_MS: cfg_reg.zero_debounce_ms <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.ready)
        begin
            in_valid_reg <= item.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_item_reg <= item.payload;
        end
    end

    rfz_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .item   (in_item_reg),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_result_reg <= result_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.payload = out_result_reg;

endmodule

FILE: design/rfz_checker.sv
// ----------------------------------------------------------------------------
// rfz_checker
// Port-level checks on the monitor, attached to the top level by bind.
// ----------------------------------------------------------------------------
module rfz_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       in_command,
    input logic       out_valid,
    input logic       out_ready,
    input logic       failsafe_active,
    input logic       throttle_idle,
    input logic       receiver_present,
    input logic [1:0] low_count
);

    logic frame_seen_reg;

    // a frame transaction has been taken at the input
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_seen_reg <= 1'b0;
        end
        else if (in_valid && in_ready && (in_command == rfz_pkg::CMD_FRAME))
        begin
            frame_seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_present_after_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && receiver_present |-> frame_seen_reg)
        else $error("receiver present without any frame");

    a_full_count_failsafe: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (low_count == 2'd3) |-> failsafe_active)
        else $error("low count at limit without failsafe");

    a_count_needs_receiver: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (low_count != 2'd0) |-> receiver_present)
        else $error("low count moved before any frame");

    a_zero_needs_receiver: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !throttle_idle |-> receiver_present)
        else $error("throttle idle cleared before any frame");

endmodule

bind radio_failsafe_throttle_zero_monitor_unit rfz_checker u_rfz_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (item.valid),
    .in_ready         (item.ready),
    .in_command       (item.payload.command),
    .out_valid        (result.valid),
    .out_ready        (result.ready),
    .failsafe_active  (result.payload.failsafe_active),
    .throttle_idle    (result.payload.throttle_idle),
    .receiver_present (result.payload.receiver_present),
    .low_count        (result.payload.low_count)
);

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the radio failsafe and throttle-zero monitor. A
// short table of directed transactions runs first, then several phases of
// random frames and polls, each under its own register setting. Each result
// transaction is compared with the table's answer or the in-bench prediction.
// ----------------------------------------------------------------------------
module testbench;

    typedef struct {
        rfz_pkg::item_t   stim;
        bit               typed;
        rfz_pkg::result_t answer;
    } stim_row_t;

    typedef struct {
        logic        enable;
        logic [11:0] pwm_floor;
        logic [15:0] timeout;
        logic [15:0] debounce;
    } setting_t;

    localparam int unsigned ITEMS_PER_PHASE = 95;
    localparam int unsigned HOLD_CYCLES     = 200;

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_we;
    rfz_pkg::cfg_index_t            cfg_index;
    logic [rfz_pkg::CFG_DATA_W-1:0] cfg_data;

    rfz_item_if   item_ch ();
    rfz_result_if result_ch ();

    radio_failsafe_throttle_zero_monitor_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predicted monitor state and register copy
    rfz_pkg::cfg_t    monitor_cfg;
    logic             engaged;
    int unsigned      low_run;
    logic             rx_seen;
    logic [31:0]      frame_stamp;
    logic [31:0]      run_stamp;
    logic             idle_zero;

    rfz_pkg::result_t expected_results[$];
    stim_row_t        directed[$];
    int unsigned      mismatch_count;

    // stimulus state
    logic             row_typed;
    rfz_pkg::result_t row_answer;
    bit               calm;
    bit               hold_request;
    logic [31:0]      sim_ms;
    int unsigned      pwm_run_left;
    bit               pwm_run_low;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #5_000_000;
        $display("radio_failsafe_throttle_zero_monitor_unit test failed");
        $finish;
    end

    function automatic rfz_pkg::result_t monitor_step(input rfz_pkg::item_t it);
        logic [31:0]      gap;
        logic             running;
        rfz_pkg::result_t r;
        if (it.command == rfz_pkg::CMD_FRAME)
        begin
            if (monitor_cfg.failsafe_enable)
            begin
                if (it.throttle_pulse < monitor_cfg.low_throttle_pwm)
                begin
                    if (!engaged && (rx_seen || it.motors_armed))
                    begin
                        low_run++;
                        if (low_run >= int'(rfz_pkg::LOW_COUNT_LIMIT))
                        begin
                            low_run = int'(rfz_pkg::LOW_COUNT_LIMIT);
                            engaged = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (low_run > 0)
                        low_run--;
                    if (low_run == 0)
                        engaged = 1'b0;
                end
            end
            running = (!it.interlock_in_use && it.throttle_level != 10'd0 && !it.estop_active)
                      || (it.interlock_in_use && it.interlock_on) || it.airmode_active;
            if (running)
            begin
                run_stamp = it.now_ms;
                idle_zero = 1'b0;
            end
            else
            begin
                gap = it.now_ms - run_stamp;
                if (gap > {16'd0, monitor_cfg.zero_debounce_ms})
                    idle_zero = 1'b1;
            end
            rx_seen     = 1'b1;
            frame_stamp = it.now_ms;
        end
        else if (!engaged)
        begin
            gap = it.now_ms - frame_stamp;
            if (gap >= {16'd0, monitor_cfg.frame_timeout_ms} && monitor_cfg.failsafe_enable
                && (rx_seen || it.motors_armed))
                engaged = 1'b1;
        end
        r.failsafe_active  = engaged;
        r.throttle_idle    = idle_zero;
        r.receiver_present = rx_seen;
        r.low_count        = low_run[rfz_pkg::LOW_CNT_W-1:0];
        return r;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(0, 99) < 36);
    endfunction

    function automatic rfz_pkg::item_t junk_item();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return rfz_pkg::item_t'(bits[$bits(rfz_pkg::item_t)-1:0]);
    endfunction

    task automatic report_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // receiver side
    initial
    begin : result_sink
        int unsigned hold_left;
        hold_left = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= !idle_now();
        end
    end

    always @(posedge clk)
    begin : watch
        rfz_pkg::result_t predicted;
        rfz_pkg::result_t want;
        rfz_pkg::result_t got;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                predicted = monitor_step(item_ch.payload);
                expected_results.push_back(row_typed ? row_answer : predicted);
            end
            if (result_ch.valid && result_ch.ready)
            begin
                got = result_ch.payload;
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result transaction %b", $time, got);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    report_field("failsafe_active", int'(want.failsafe_active),
                                 int'(got.failsafe_active));
                    report_field("throttle_idle", int'(want.throttle_idle),
                                 int'(got.throttle_idle));
                    report_field("receiver_present", int'(want.receiver_present),
                                 int'(got.receiver_present));
                    report_field("low_count", int'(want.low_count), int'(got.low_count));
                end
            end
        end
    end

    task automatic offer_item(input rfz_pkg::item_t it, input bit typed,
                              input rfz_pkg::result_t answer);
        @(negedge clk);
        while (idle_now())
        begin
            item_ch.valid   <= 1'b0;
            item_ch.payload <= junk_item();
            @(negedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        row_typed       <= typed;
        row_answer      <= answer;
        do
            @(posedge clk);
        while (!item_ch.ready);
    endtask

    task automatic drain_results();
        @(negedge clk);
        item_ch.valid <= 1'b0;
        wait (expected_results.size() == 0);
    endtask

    task automatic write_register(input rfz_pkg::cfg_index_t idx,
                                  input logic [rfz_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            rfz_pkg::CFG_FAILSAFE_ENABLE:  monitor_cfg.failsafe_enable  = data[0];
            rfz_pkg::CFG_LOW_THROTTLE_PWM: monitor_cfg.low_throttle_pwm = data[11:0];
            rfz_pkg::CFG_FRAME_TIMEOUT_MS: monitor_cfg.frame_timeout_ms = data;
            rfz_pkg::CFG_ZERO_DEBOUNCE_MS: monitor_cfg.zero_debounce_ms = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_setting(input setting_t s);
        logic [14:0] pad_hi;
        logic [3:0]  pad_lo;
        pad_hi = 15'($urandom);
        pad_lo = 4'($urandom);
        write_register(rfz_pkg::CFG_FAILSAFE_ENABLE, {pad_hi, s.enable});
        write_register(rfz_pkg::CFG_LOW_THROTTLE_PWM, {pad_lo, s.pwm_floor});
        write_register(rfz_pkg::CFG_FRAME_TIMEOUT_MS, s.timeout);
        write_register(rfz_pkg::CFG_ZERO_DEBOUNCE_MS, s.debounce);
    endtask

    function automatic void add_directed(input logic cmd, input logic [31:0] now,
                                         input logic [11:0] pwm, input logic [9:0] level,
                                         input logic [4:0] flags, input bit typed,
                                         input logic [4:0] answer);
        stim_row_t row;
        row.stim.command          = cmd;
        row.stim.now_ms           = now;
        row.stim.throttle_pulse   = pwm;
        row.stim.throttle_level   = level;
        // flags: armed, interlock in use, interlock on, estop, airmode
        row.stim.motors_armed     = flags[4];
        row.stim.interlock_in_use = flags[3];
        row.stim.interlock_on     = flags[2];
        row.stim.estop_active     = flags[1];
        row.stim.airmode_active   = flags[0];
        row.typed                 = typed;
        row.answer                = rfz_pkg::result_t'(answer);
        directed.push_back(row);
    endfunction

    function automatic rfz_pkg::item_t random_item();
        rfz_pkg::item_t it;
        int unsigned    pick;
        logic [11:0]    floor_pwm;
        floor_pwm = monitor_cfg.low_throttle_pwm;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            sim_ms += $urandom_range(0, 300);
        else if (pick < 90)
            sim_ms += $urandom_range(300, 2500);
        else if (pick < 95)
            sim_ms += $urandom_range(60000, 70000);
        else
            sim_ms += $urandom;
        it.command = ($urandom_range(0, 99) < 65) ? rfz_pkg::CMD_FRAME : rfz_pkg::CMD_POLL;
        it.now_ms  = sim_ms;
        if (pwm_run_left == 0)
        begin
            pwm_run_left = $urandom_range(1, 6);
            pwm_run_low  = 1'($urandom_range(0, 1));
        end
        pwm_run_left--;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            it.throttle_pulse = 12'($urandom);
        else if (pwm_run_low && floor_pwm != 12'd0)
            it.throttle_pulse = (pick < 20) ? floor_pwm - 12'd1
                                            : 12'($urandom_range(0, floor_pwm - 1));
        else
            it.throttle_pulse = (pick < 20) ? floor_pwm
                                            : 12'($urandom_range(floor_pwm, 4095));
        it.throttle_level   = ($urandom_range(0, 1) == 0) ? 10'd0
                                                          : 10'($urandom_range(0, 1000));
        it.motors_armed     = 1'($urandom_range(0, 1));
        it.interlock_in_use = ($urandom_range(0, 99) < 30);
        it.interlock_on     = 1'($urandom_range(0, 1));
        it.estop_active     = ($urandom_range(0, 99) < 25);
        it.airmode_active   = ($urandom_range(0, 99) < 15);
        return it;
    endfunction

    initial
    begin : main
        setting_t         settings[8];
        rfz_pkg::result_t unused;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = rfz_pkg::CFG_FAILSAFE_ENABLE;
        cfg_data        = '0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        row_typed       = 1'b0;
        row_answer      = '0;
        calm            = 1'b0;
        hold_request    = 1'b0;
        mismatch_count  = 0;
        pwm_run_left    = 0;
        pwm_run_low     = 1'b0;
        sim_ms          = '0;
        unused          = '0;

        monitor_cfg.failsafe_enable  = rfz_pkg::RST_FAILSAFE_ENABLE;
        monitor_cfg.low_throttle_pwm = rfz_pkg::RST_LOW_THROTTLE_PWM;
        monitor_cfg.frame_timeout_ms = rfz_pkg::RST_FRAME_TIMEOUT_MS;
        monitor_cfg.zero_debounce_ms = rfz_pkg::RST_ZERO_DEBOUNCE_MS;
        engaged     = 1'b0;
        low_run     = 0;
        rx_seen     = 1'b0;
        frame_stamp = '0;
        run_stamp   = '0;
        idle_zero   = 1'b1;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: enable 1, floor 975, timeout 1000, debounce 400
        add_directed(rfz_pkg::CMD_POLL,  32'd0,    12'd0,    10'd0,    5'b00000, 1, 5'b01000);
        add_directed(rfz_pkg::CMD_POLL,  32'd5000, 12'd0,    10'd0,    5'b00000, 1, 5'b01000);
        // armed with no receiver yet times out
        add_directed(rfz_pkg::CMD_POLL,  32'd5000, 12'd0,    10'd0,    5'b10000, 1, 5'b11000);
        add_directed(rfz_pkg::CMD_FRAME, 32'd5000, 12'd4095, 10'd0,    5'b00000, 1, 5'b01100);
        add_directed(rfz_pkg::CMD_FRAME, 32'd5010, 12'd0,    10'd0,    5'b00000, 1, 5'b01101);
        add_directed(rfz_pkg::CMD_FRAME, 32'd5020, 12'd974,  10'd0,    5'b00000, 1, 5'b01110);
        add_directed(rfz_pkg::CMD_FRAME, 32'd5030, 12'd0,    10'd0,    5'b00000, 1, 5'b11111);
        add_directed(rfz_pkg::CMD_FRAME, 32'd5040, 12'd0,    10'd0,    5'b00000, 1, 5'b11111);
        add_directed(rfz_pkg::CMD_FRAME, 32'd5050, 12'd975,  10'd1000, 5'b00000, 1, 5'b10110);
        add_directed(rfz_pkg::CMD_FRAME, 32'd5060, 12'd4095, 10'd0,    5'b00000, 1, 5'b10101);
        add_directed(rfz_pkg::CMD_FRAME, 32'd5070, 12'd2000, 10'd0,    5'b00000, 1, 5'b00100);
        add_directed(rfz_pkg::CMD_POLL,  32'd6069, 12'd0,    10'd0,    5'b00000, 1, 5'b00100);
        add_directed(rfz_pkg::CMD_POLL,  32'd6070, 12'd0,    10'd0,    5'b00000, 1, 5'b10100);
        add_directed(rfz_pkg::CMD_POLL,  32'hFFFF_FFFF, 12'd4095, 10'd1000, 5'b11111, 1,
                     5'b10100);
        // debounce across the wrap of the millisecond counter
        add_directed(rfz_pkg::CMD_FRAME, 32'hFFFF_FFF0, 12'd4095, 10'd0, 5'b01100, 0,
                     5'b00000);
        add_directed(rfz_pkg::CMD_FRAME, 32'h0000_0180, 12'd4095, 10'd0, 5'b00000, 0,
                     5'b00000);
        add_directed(rfz_pkg::CMD_FRAME, 32'h0000_0181, 12'd4095, 10'd0, 5'b00000, 0,
                     5'b00000);
        add_directed(rfz_pkg::CMD_FRAME, 32'h0000_0200, 12'd4095, 10'd1000, 5'b00010, 1,
                     5'b01100);
        add_directed(rfz_pkg::CMD_FRAME, 32'h0000_0210, 12'd4095, 10'd1000, 5'b01000, 1,
                     5'b01100);
        add_directed(rfz_pkg::CMD_FRAME, 32'h0000_0220, 12'd4095, 10'd0,    5'b00011, 1,
                     5'b00100);
        add_directed(rfz_pkg::CMD_FRAME, 32'h0000_0230, 12'd4095, 10'd1,    5'b00000, 1,
                     5'b00100);
        add_directed(rfz_pkg::CMD_POLL,  32'h0000_0618, 12'd0,    10'd0,    5'b00000, 0,
                     5'b00000);
        add_directed(rfz_pkg::CMD_FRAME, 32'h0000_0620, 12'd4095, 10'd1000, 5'b11111, 0,
                     5'b00000);

        foreach (directed[i])
            offer_item(directed[i].stim, directed[i].typed, directed[i].answer);
        drain_results();

        settings[0] = '{1'b1, 12'd975,  16'd1000,  16'd400};
        settings[1] = '{1'b0, 12'd975,  16'd1000,  16'd400};
        settings[2] = '{1'b1, 12'd0,    16'd1000,  16'd400};
        settings[3] = '{1'b1, 12'd4095, 16'd0,     16'd0};
        settings[4] = '{1'b1, 12'd2000, 16'd65535, 16'd65535};
        settings[5] = '{1'b1, 12'd1500, 16'd0,     16'd65535};
        for (int k = 6; k < 8; k++)
            settings[k] = '{1'($urandom_range(0, 1)), 12'($urandom),
                            16'($urandom_range(0, 3000)), 16'($urandom_range(0, 3000))};

        foreach (settings[p])
        begin
            apply_setting(settings[p]);
            calm = (p == 3);
            if (p == 5)
                sim_ms = 32'hFFFF_F000;
            if (p == 2 || p == 6)
                hold_request = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                offer_item(random_item(), 1'b0, unused);
            drain_results();
        end
        calm = 1'b0;

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("radio_failsafe_throttle_zero_monitor_unit test passed");
        else
            $display("radio_failsafe_throttle_zero_monitor_unit test failed");
        $finish;
    end

endmodule

FILE: files.f
design/rfz_pkg.sv
design/rfz_if.sv
design/rfz_core.sv
design/radio_failsafe_throttle_zero_monitor_unit.sv
design/rfz_checker.sv
sim/testbench.sv
